>>> hdl/length_framed_sum_checked_parser_defines.svh
// Assertion helpers shared by the RTL.
`ifndef LENGTH_FRAMED_SUM_CHECKED_PARSER_DEFINES_SVH
`define LENGTH_FRAMED_SUM_CHECKED_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFSCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFSCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lfscp_pkg.sv
`default_nettype none

package lfscp_pkg;

   localparam int BYTE_W     = 8;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET   = 8'h5A;
   localparam logic [BYTE_W-1:0] WANTED_TYPE_RESET = 8'h82;

   localparam logic [POS_W-1:0] POS_SYNC0   = 9'd0;
   localparam logic [POS_W-1:0] POS_SYNC1   = 9'd1;
   localparam logic [POS_W-1:0] POS_TYPE    = 9'd2;
   localparam logic [POS_W-1:0] POS_LENGTH  = 9'd3;
   localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd4;
   localparam logic [POS_W-1:0] POS_LAST    = 9'd259;

   typedef enum logic {
      CSR_SYNC_BYTE   = 1'b0,
      CSR_WANTED_TYPE = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

>>> hdl/length_framed_sum_checked_parser.sv
// Frame parser for a received byte stream.
// The request channel (req_tvalid, req_tready, req_tdata) carries one received
// byte per request. Frames are two sync bytes, a type byte, a length byte, that
// many payload bytes and a checksum byte equal to the 8-bit sum of all earlier
// frame bytes. Bytes that fail a sync match are dropped.
// The response channel (rsp_tvalid, rsp_tready, rsp_tdata) carries one 32-bit
// value for each frame that ends with a good checksum and the wanted type: the
// first four payload bytes, big-endian, with absent bytes read as zero.
// The response is registered in the cycle after the checksum byte is taken, and
// one byte is taken every cycle unless a pending response holds req_tready low.
// A response waits in its output register while the receiver stalls; a new byte
// is still taken in that cycle when the receiver takes the pending response,
// otherwise req_tready drops.
// The APB port holds the sync byte at address 0 and the wanted type at address
// 4. Synchronous reset returns the parser to the search for a first sync byte,
// empties the response register and restores 0x5A and 0x82.
`default_nettype none
`include "length_framed_sum_checked_parser_defines.svh"

module length_framed_sum_checked_parser
   import lfscp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [VALUE_W-1:0]         rsp_tdata,   // [31:0] measured_value
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [BYTE_W-1:0]  sync_ff, wanted_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [BYTE_W-1:0]  type_ff, type_in;
   logic [BYTE_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               csr_write;
   csr_index_type      csr_index;
   logic [POS_W-1:0]   payload_index;
   logic               in_payload;
   logic               at_checksum;
   logic [BYTE_W-1:0]  rx_byte;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_index)
         CSR_SYNC_BYTE:   csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, sync_ff};
         CSR_WANTED_TYPE: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, wanted_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= SYNC_BYTE_RESET;
         wanted_ff <= WANTED_TYPE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SYNC_BYTE:   sync_ff   <= csr_pwdata[BYTE_W-1:0];
            CSR_WANTED_TYPE: wanted_ff <= csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rx_byte    = req_tdata;

   assign payload_index = pos_ff - POS_PAYLOAD;
   assign in_payload    = (pos_ff >= POS_PAYLOAD) &&
                          (payload_index < {1'b0, len_ff});
   assign at_checksum   = (pos_ff >= POS_PAYLOAD) && !in_payload;

   always_comb begin
      pos_in       = pos_ff;
      type_in      = type_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         if (pos_ff == POS_SYNC0) begin
            if (rx_byte == sync_ff) begin
               sum_in = rx_byte;
               acc_in = '0;
               pos_in = POS_SYNC1;
            end
         end else if (pos_ff == POS_SYNC1) begin
            if (rx_byte == sync_ff) begin
               sum_in = sum_ff + rx_byte;
               pos_in = POS_TYPE;
            end else begin
               pos_in = POS_SYNC0;
            end
         end else if (pos_ff == POS_TYPE) begin
            type_in = rx_byte;
            sum_in  = sum_ff + rx_byte;
            pos_in  = POS_LENGTH;
         end else if (pos_ff == POS_LENGTH) begin
            len_in = rx_byte;
            sum_in = sum_ff + rx_byte;
            pos_in = POS_PAYLOAD;
         end else if (in_payload) begin
            if (payload_index < POS_PAYLOAD) begin
               case (payload_index[1:0])
                  2'd0:    acc_in[31:24] = acc_ff[31:24] | rx_byte;
                  2'd1:    acc_in[23:16] = acc_ff[23:16] | rx_byte;
                  2'd2:    acc_in[15:8]  = acc_ff[15:8]  | rx_byte;
                  default: acc_in[7:0]   = acc_ff[7:0]   | rx_byte;
               endcase
            end
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + 9'd1;
         end else begin
            pos_in = POS_SYNC0;
            if ((sum_ff == rx_byte) && (type_ff == wanted_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_SYNC0;
         type_ff      <= '0;
         len_ff       <= '0;
         sum_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         type_ff      <= type_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `LFSCP_ASSERT_SAME(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_LAST,
      "frame position past the checksum slot")
   `LFSCP_ASSERT_NEXT(a_checksum_restarts, clock, reset, req_accept && at_checksum,
      pos_ff == POS_SYNC0, "parser did not restart after the checksum byte")
   `LFSCP_ASSERT_NEXT(a_bad_sync_dropped, clock, reset,
      req_accept && (pos_ff == POS_SYNC0) && (rx_byte != sync_ff),
      pos_ff == POS_SYNC0, "bad first sync byte advanced the parser")
   `LFSCP_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !rsp_valid_ff && !req_accept,
      !rsp_valid_ff, "response appeared without a request")

endmodule

`default_nettype wire
